>>> rtl/pfe_pkg.sv
// Package for the Playfair encryption stream: shared types, letter codes
// and the key square lookup functions. No dependencies.
package pfe_pkg;

	localparam int unsigned SQ        = 5;
	localparam int unsigned CODE_W    = 5;
	localparam int unsigned ROW_W     = SQ * CODE_W;
	localparam int unsigned POS_W     = 3;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QAW       = 2;
	localparam int unsigned NREG      = 5;
	localparam int unsigned ADDR_W    = 5;

	localparam logic [4:0] CODE_I = 5'd8;
	localparam logic [4:0] CODE_J = 5'd9;
	localparam logic [4:0] CODE_X = 5'd23;
	localparam logic [POS_W-1:0] POS_LAST = 3'd4;

	localparam logic [7:0] ASCII_UA = 8'h41;
	localparam logic [7:0] ASCII_UZ = 8'h5A;
	localparam logic [7:0] ASCII_LA = 8'h61;
	localparam logic [7:0] ASCII_LZ = 8'h7A;

	typedef logic [SQ-1:0][ROW_W-1:0] key_rows_t;

	// One digraph request handed from the front to the back.
	typedef struct packed {
		logic [CODE_W-1:0] a;
		logic [CODE_W-1:0] b;
		logic              eom;
	} pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [POS_W-1:0] r;
		logic [POS_W-1:0] c;
	} pos_t;

	function automatic logic [CODE_W-1:0] sq_get(key_rows_t rows, logic [POS_W-1:0] r,
		logic [POS_W-1:0] c);
		logic [ROW_W-1:0] row;
		row = rows[r];
		return row[c*CODE_W +: CODE_W];
	endfunction

	// First match in row order, then column order; no match gives row 0, column 0.
	function automatic pos_t sq_find(key_rows_t rows, logic [CODE_W-1:0] code);
		pos_t p;
		p = '0;
		for (int i = SQ - 1; i >= 0; i--) begin
			for (int k = SQ - 1; k >= 0; k--) begin
				if (rows[i][k*CODE_W +: CODE_W] == code) begin
					p.r = POS_W'(i);
					p.c = POS_W'(k);
				end
			end
		end
		return p;
	endfunction

	function automatic logic [POS_W-1:0] pos_next(logic [POS_W-1:0] v);
		return (v == POS_LAST) ? '0 : POS_W'(v + 1'b1);
	endfunction

endpackage

>>> rtl/pfe_front.sv
// Front part of the Playfair stream: classifies bytes, holds the waiting
// letter and issues digraph requests into the queue. Depends on pfe_pkg.
module pfe_front
	import pfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_char,
	input  logic        last_char,
	input  logic        in_valid,
	output logic        in_ready,
	input  q_stat_t     q_stat,
	output logic        push,
	output pair_t       push_data
);

	logic [CODE_W-1:0] held_letter_q;
	logic              held_valid_q;
	logic              pend_valid_q;
	pair_t             pend_q;

	logic              accept;
	logic              is_letter;
	logic [CODE_W-1:0] code;
	logic              first_v;
	pair_t             first_p;
	logic              second_v;
	pair_t             second_p;
	logic [CODE_W-1:0] held_d;
	logic              held_v_d;

	assign in_ready = !pend_valid_q && !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_letter = 1'b0;
		code      = '0;
		if (in_char inside {[ASCII_LA:ASCII_LZ]}) begin
			is_letter = 1'b1;
			code      = CODE_W'(in_char - ASCII_LA);
		end else if (in_char inside {[ASCII_UA:ASCII_UZ]}) begin
			is_letter = 1'b1;
			code      = CODE_W'(in_char - ASCII_UA);
		end
		if (code == CODE_J) begin
			code = CODE_I;
		end
	end

	always_comb begin
		first_v  = 1'b0;
		first_p  = '{a: held_letter_q, b: CODE_X, eom: 1'b0};
		second_v = 1'b0;
		second_p = '{a: code, b: CODE_X, eom: 1'b1};
		held_d   = held_letter_q;
		held_v_d = held_valid_q;
		if (is_letter) begin
			if (!held_valid_q) begin
				held_d   = code;
				held_v_d = 1'b1;
				if (last_char) begin
					first_v  = 1'b1;
					first_p  = '{a: code, b: CODE_X, eom: 1'b1};
					held_d   = '0;
					held_v_d = 1'b0;
				end
			end else if (code == held_letter_q) begin
				first_v = 1'b1;
				held_d  = code;
				if (last_char) begin
					second_v = 1'b1;
					held_d   = '0;
					held_v_d = 1'b0;
				end
			end else begin
				first_v  = 1'b1;
				first_p  = '{a: held_letter_q, b: code, eom: last_char};
				held_d   = '0;
				held_v_d = 1'b0;
			end
		end else if (last_char && held_valid_q) begin
			first_v  = 1'b1;
			first_p  = '{a: held_letter_q, b: CODE_X, eom: 1'b1};
			held_d   = '0;
			held_v_d = 1'b0;
		end
	end

	assign push      = pend_valid_q ? !q_stat.full : (accept && first_v);
	assign push_data = pend_valid_q ? pend_q : first_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				held_letter_q <= held_d;
				held_valid_q  <= held_v_d;
				pend_valid_q  <= second_v;
			end else if (pend_valid_q && !q_stat.full) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= second_p;
		end
	end

endmodule

>>> rtl/pfe_fifo.sv
// Short request queue between the front and back parts of the Playfair
// stream. Depends on pfe_pkg.
module pfe_fifo
	import pfe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  pair_t   wdata,
	input  logic    pop,
	output pair_t   rdata,
	output q_stat_t stat
);

	pair_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign stat.full  = (count_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QAW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QAW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= (QAW+1)'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= (QAW+1)'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/pfe_back.sv
// Back part of the Playfair stream: locates both letters in the key square,
// applies the row, column or rectangle rule and sends out two letters.
// Depends on pfe_pkg.
module pfe_back
	import pfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  key_rows_t   rows,
	input  q_stat_t     q_stat,
	input  pair_t       head,
	output logic        pop,
	output logic [6:0]  cipher_letter,
	output logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready
);

	logic              valid_s1;
	pos_t              p1_s1;
	pos_t              p2_s1;
	logic              eom_s1;

	logic              out_v_q;
	logic [CODE_W-1:0] o1_q;
	logic [CODE_W-1:0] o2_q;
	logic              eom_q;
	logic              phase_q;

	logic              pair_free;
	logic              load_pair;
	logic              s1_free;
	logic [CODE_W-1:0] o1;
	logic [CODE_W-1:0] o2;
	logic [CODE_W-1:0] sel;

	assign pair_free = !out_v_q || (out_ready && phase_q);
	assign load_pair = valid_s1 && pair_free;
	assign s1_free   = !valid_s1 || load_pair;
	assign pop       = !q_stat.empty && s1_free;

	always_comb begin
		if (p1_s1.r == p2_s1.r) begin
			o1 = sq_get(rows, p1_s1.r, pos_next(p1_s1.c));
			o2 = sq_get(rows, p2_s1.r, pos_next(p2_s1.c));
		end else if (p1_s1.c == p2_s1.c) begin
			o1 = sq_get(rows, pos_next(p1_s1.r), p1_s1.c);
			o2 = sq_get(rows, pos_next(p2_s1.r), p2_s1.c);
		end else begin
			o1 = sq_get(rows, p1_s1.r, p2_s1.c);
			o2 = sq_get(rows, p2_s1.r, p1_s1.c);
		end
	end

	assign sel            = phase_q ? o2_q : o1_q;
	assign cipher_letter  = 7'(7'h41 + {2'b00, sel});
	assign end_of_message = eom_q && phase_q;
	assign out_valid      = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= pop;
			end
			if (load_pair) begin
				out_v_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (out_v_q && out_ready) begin
				if (phase_q) begin
					out_v_q <= 1'b0;
				end
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			p1_s1  <= sq_find(rows, head.a);
			p2_s1  <= sq_find(rows, head.b);
			eom_s1 <= head.eom;
		end
		if (load_pair) begin
			o1_q  <= o1;
			o2_q  <= o2;
			eom_q <= eom_s1;
		end
	end

endmodule

>>> rtl/playfair_encrypt_stream.sv
// Top level of the Playfair encryption stream: key square registers on the
// APB port, front, request queue and back. Depends on pfe_pkg and submodules.
//
// The block takes one plaintext byte per request on the in channel and returns
// ciphertext letters as upper-case ASCII on the out channel. Non-letters are
// dropped, lower case folds to upper case and J becomes I. A repeated letter
// is split with X, and a lone letter at the end of a message (last_char set)
// is padded with X; end_of_message marks the final letter of such a message.
// Each accepted byte is classified at the input; each digraph then has its
// letters located (registered positions), has the cipher rule applied
// (registered letter pair) and leaves as two letters in turn, so the output
// port sets the sustained rate. A byte that yields two digraphs (a doubled
// letter at the end of a message) holds the input until its second request
// is pushed into the queue. The four-entry request queue lets the input keep
// flowing while the output is stalled. The key square is five registers at
// byte addresses 0, 4, 8, 12 and 16, each holding five 5-bit letter codes
// with column 0 in the low bits; write them only while the block is idle.
module playfair_encrypt_stream
	import pfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_char,
	input  logic              last_char,
	input  logic              in_valid,
	output logic              in_ready,
	output logic [6:0]        cipher_letter,
	output logic              end_of_message,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	key_rows_t key_row_q;
	logic [2:0] reg_idx;
	logic       cfg_wr;

	q_stat_t q_stat;
	logic    push;
	pair_t   push_data;
	logic    pop;
	pair_t   head;

	// Register index is the word address; indexes past the last row are ignored.
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_row_q <= '0;
		end else if (cfg_wr && (reg_idx < 3'(NREG))) begin
			key_row_q[reg_idx] <= pwdata[ROW_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx < 3'(NREG)) begin
			prdata = {7'b0, key_row_q[reg_idx]};
		end
	end

	// The front classifies bytes and keeps the held letter.
	pfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_char   (in_char),
		.last_char (last_char),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	pfe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (head),
		.stat   (q_stat)
	);

	// The back enciphers each digraph and serializes the two letters.
	pfe_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rows           (key_row_q),
		.q_stat         (q_stat),
		.head           (head),
		.pop            (pop),
		.cipher_letter  (cipher_letter),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready)
	);

	// The front must never push into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("request pushed into full queue");

	// The back must never pop an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("request popped from empty queue");

	// Input is refused while the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !in_ready)
		else $error("input ready while queue full");

endmodule

>>> tb/sv/pfe_cipher_check.sv
// Checker for the Playfair encryption stream: watches the byte, letter and
// register ports, predicts the letters each accepted byte causes and compares.
// Depends on pfe_pkg for letter codes, ASCII bounds and port widths.
module pfe_cipher_check
	import pfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_char,
	input  logic              last_char,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [6:0]        cipher_letter,
	input  logic              end_of_message,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                letters_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0] letter;
		logic       eom;
	} cipher_out_t;

	typedef struct {
		int unsigned row;
		int unsigned col;
	} grid_pos_t;

	logic [ROW_W-1:0]  key_row [NREG];
	logic [CODE_W-1:0] held_code;
	logic              held_on;
	cipher_out_t       cipher_due_q [$];
	int                fails;

	function automatic logic [CODE_W-1:0] square_at(int unsigned r, int unsigned c);
		return key_row[r % SQ][CODE_W * (c % SQ) +: CODE_W];
	endfunction

	// First match in row order wins; a letter absent from the square sits at 0,0.
	function automatic grid_pos_t locate(logic [CODE_W-1:0] code);
		grid_pos_t p;
		p.row = 0;
		p.col = 0;
		for (int r = 0; r < SQ; r++) begin
			for (int c = 0; c < SQ; c++) begin
				if (square_at(r, c) == code) begin
					p.row = r;
					p.col = c;
					return p;
				end
			end
		end
		return p;
	endfunction

	task automatic encipher_pair(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b);
		grid_pos_t         pa;
		grid_pos_t         pb;
		logic [CODE_W-1:0] oa;
		logic [CODE_W-1:0] ob;
		pa = locate(a);
		pb = locate(b);
		if (pa.row == pb.row) begin
			oa = square_at(pa.row, pa.col + 1);
			ob = square_at(pb.row, pb.col + 1);
		end else if (pa.col == pb.col) begin
			oa = square_at(pa.row + 1, pa.col);
			ob = square_at(pb.row + 1, pb.col);
		end else begin
			oa = square_at(pa.row, pb.col);
			ob = square_at(pb.row, pa.col);
		end
		cipher_due_q.push_back({7'(65 + oa), 1'b0});
		cipher_due_q.push_back({7'(65 + ob), 1'b0});
	endtask

	task automatic take_byte(input logic [7:0] ch, input logic fin);
		logic [CODE_W-1:0] code;
		logic              letter;
		int                n;
		cipher_out_t       tail;
		code = '0;
		letter = 1'b0;
		n = 0;
		if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
			code = CODE_W'(ch - ASCII_LA);
			letter = 1'b1;
		end else if (ch >= ASCII_UA && ch <= ASCII_UZ) begin
			code = CODE_W'(ch - ASCII_UA);
			letter = 1'b1;
		end
		if (letter && code == CODE_J)
			code = CODE_I;
		if (letter) begin
			if (!held_on) begin
				held_code = code;
				held_on = 1'b1;
			end else if (code == held_code) begin
				// Repeated letter: split with X and keep the new one waiting.
				encipher_pair(held_code, CODE_X);
				n += 2;
			end else begin
				encipher_pair(held_code, code);
				n += 2;
				held_on = 1'b0;
				held_code = '0;
			end
		end
		if (fin) begin
			if (held_on) begin
				encipher_pair(held_code, CODE_X);
				n += 2;
				held_on = 1'b0;
				held_code = '0;
			end
			if (n > 0) begin
				tail = cipher_due_q.pop_back();
				tail.eom = 1'b1;
				cipher_due_q.push_back(tail);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cipher_out_t want;
		if (!arst_n) begin
			cipher_due_q.delete();
			for (int i = 0; i < NREG; i++)
				key_row[i] = '0;
			held_code = '0;
			held_on = 1'b0;
			fails = 0;
			letters_due <= 0;
			fail_count <= 0;
		end else begin
			// Letters leave first so a byte taken at this edge cannot match one.
			if (out_valid && out_ready) begin
				if (cipher_due_q.size() == 0) begin
					$error("cipher_letter: expected none, actual %0d", cipher_letter);
					fails++;
				end else begin
					want = cipher_due_q.pop_front();
					if (cipher_letter !== want.letter) begin
						$error("cipher_letter: expected %0d, actual %0d",
							want.letter, cipher_letter);
						fails++;
					end
					if (end_of_message !== want.eom) begin
						$error("end_of_message: expected %0d, actual %0d",
							want.eom, end_of_message);
						fails++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < NREG)
				key_row[paddr[ADDR_W-1:2]] = pwdata[ROW_W-1:0];
			if (in_valid && in_ready)
				take_byte(in_char, last_char);
			letters_due <= cipher_due_q.size();
			fail_count <= fails;
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the Playfair encryption stream testbench: clock, reset, byte and
// register stimulus, output back-pressure and the verdict.
// Depends on pfe_pkg, playfair_encrypt_stream and pfe_cipher_check.
module testbench;
	import pfe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Generous bound on the whole run; the slowest legal run is far shorter.
	localparam int CYCLE_LIMIT = 500000;

	// Opening sequence under the classic key square, each entry {last, byte}.
	// It walks the row, column and rectangle rules, a doubled letter closed by
	// a final copy (four letters from one byte), a held J met by an I, a
	// doubled X and a padded X, an end marker with nothing to emit, and the
	// bytes on both sides of each letter range, plus 00 and FF.
	localparam logic [8:0] OPENING [24] = '{
		9'h050, 9'h04C,          // P L : same row
		9'h04C, 9'h052,          // L R : same column
		9'h045, 9'h045, 9'h165,  // E E e(last) : split, then pad
		9'h04A, 9'h049, 9'h07A,  // J I z : J becomes I, split, rectangle
		9'h058, 9'h058, 9'h121,  // X X !(last) : doubled X, pad a held X
		9'h17E,                  // ~(last) : end with nothing held
		9'h040, 9'h041, 9'h05B, 9'h05A, // @ A [ Z
		9'h060, 9'h061, 9'h07B, 9'h07A, // ` a { z
		9'h000, 9'h1FF           // extremes of the byte, last on a non-letter
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [7:0]        in_char = '0;
	logic              last_char = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [6:0]        cipher_letter;
	logic              end_of_message;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                fail_count;
	int                letters_due;
	int                cycles = 0;
	bit                sender_quiet = 1'b0;
	bit                sink_quiet = 1'b0;

	always #10ns clk = ~clk;

	playfair_encrypt_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_char       (in_char),
		.last_char     (last_char),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cipher_letter (cipher_letter),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	pfe_cipher_check cipher_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_char       (in_char),
		.last_char     (last_char),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cipher_letter (cipher_letter),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.letters_due   (letters_due)
	);

	// Watchdog: a hang or a letter that never arrives ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Any byte that is not an ASCII letter, drawn at random.
	function automatic logic [7:0] non_letter();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while ((b >= ASCII_UA && b <= ASCII_UZ) || (b >= ASCII_LA && b <= ASCII_LZ));
		return b;
	endfunction

	// A well-formed key square: the 25 letters other than J in random order.
	function automatic logic [SQ-1:0][ROW_W-1:0] shuffled_square();
		logic [CODE_W-1:0]           pool [25];
		logic [CODE_W-1:0]           swap;
		logic [SQ-1:0][ROW_W-1:0]    sq;
		int                          n;
		int                          j;
		n = 0;
		for (int c = 0; c < 26; c++) begin
			if (CODE_W'(c) != CODE_J) begin
				pool[n] = CODE_W'(c);
				n++;
			end
		end
		for (int k = 24; k > 0; k--) begin
			j = $urandom_range(0, k);
			swap = pool[k];
			pool[k] = pool[j];
			pool[j] = swap;
		end
		for (int k = 0; k < 25; k++)
			sq[k / SQ][CODE_W * (k % SQ) +: CODE_W] = pool[k];
		return sq;
	endfunction

	// Register write: a setup phase, then an access phase that completes on
	// pready. An idle gap afterwards keeps back-to-back writes apart.
	task automatic apb_write(input int idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all five rows; the unused upper data bits carry random junk.
	task automatic load_square(input logic [SQ-1:0][ROW_W-1:0] sq);
		for (int i = 0; i < NREG; i++)
			apb_write(i, {7'($urandom), sq[i]});
	endtask

	// One request on the byte channel. The pause before it is drawn per byte;
	// with no pause, valid simply stays high and the payload moves on.
	task automatic send_byte(input logic [7:0] ch, input logic fin);
		int pause;
		pause = sender_quiet ? 0 : $urandom_range(0, 19);
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= ch;
		last_char <= fin;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every predicted letter has come out, then idle
	// on so that nothing is still in flight inside the block.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (letters_due != 0);
		repeat (10) @(posedge clk);
	endtask

	// One message: random letters in mixed case, frequent repeats so that
	// doubled letters get split, J standing in for I now and then, stray
	// non-letters in between. Most messages close with last_char, sometimes on
	// a trailing non-letter; the rest run on into the next message.
	task automatic send_message(output int counted);
		int                len;
		bit                closes;
		bit                fin;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] shown;
		logic [7:0]        ch;
		counted = 0;
		len = $urandom_range(1, 14);
		closes = ($urandom_range(0, 7) != 0);
		code = '0;
		for (int i = 0; i < len; i++) begin
			if (i == 0 || $urandom_range(0, 3) != 0)
				code = CODE_W'($urandom_range(0, 25));
			shown = (code == CODE_I && $urandom_range(0, 1)) ? CODE_J : code;
			ch = ($urandom_range(0, 1) ? ASCII_LA : ASCII_UA) + 8'(shown);
			if ($urandom_range(0, 7) == 0)
				send_byte(non_letter(), 1'b0);
			fin = closes && (i == len - 1);
			if (fin && $urandom_range(0, 4) == 0) begin
				send_byte(ch, 1'b0);
				send_byte(non_letter(), 1'b1);
			end else begin
				send_byte(ch, fin);
			end
			counted++;
		end
	endtask

	// A phase of random traffic under one key square. Mostly messages, with
	// one request in ten a raw random byte (any value, last_char now and then).
	// Raw bytes are not counted toward the budget.
	task automatic random_traffic(input int budget);
		int sent;
		int n;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 7) == 0)
				sender_quiet = !sender_quiet;
			if ($urandom_range(0, 9) == 0) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			end else begin
				send_message(n);
				sent += n;
			end
		end
		drain();
	endtask

	// Output side: each letter waits a random stall before ready goes high,
	// with occasional stretches of no stall at all.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				sink_quiet = !sink_quiet;
			stall = sink_quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		logic [SQ-1:0][ROW_W-1:0] square;
		string                    classic;
		int                       budget;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Square still at reset (all zero): only A is found, every other
		// letter falls back to row 0, column 0, so the pair goes out as A A.
		send_byte(ASCII_LA, 1'b0);
		send_byte(8'h42, 1'b1);
		drain();

		// The classic textbook square, then the directed opening sequence.
		classic = "PLAYFIREXMBCDGHKNOQSTUVWZ";
		for (int k = 0; k < 25; k++)
			square[k / SQ][CODE_W * (k % SQ) +: CODE_W] = CODE_W'(classic[k] - ASCII_UA);
		load_square(square);
		for (int k = 0; k < 24; k++)
			send_byte(OPENING[k][7:0], OPENING[k][8]);
		drain();

		// Random phases. The square changes only once the block has drained.
		// First the all-ones square (every cipher code 31, outside the
		// alphabet), then an explicitly written all-zero square, then raw
		// random rows with repeats and out-of-range codes, then proper
		// shuffled squares for the bulk of the traffic.
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: square = '1;
				1: square = '0;
				2: begin
					for (int r = 0; r < SQ; r++)
						square[r] = ROW_W'($urandom);
				end
				default: square = shuffled_square();
			endcase
			load_square(square);
			budget = (ph < 2) ? 15 : ((ph == 2) ? 35 : 37);
			random_traffic(budget);
		end

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
